// ===== sv/rrwl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reader-writer lock unit package
// Sizes, request and status codes, and controller types shared by the block.
// ----------------------------------------------------------------------------
package rrwl_pkg;

	// Sizing of the block.
	localparam int REQUESTERS = 16;
	localparam int LOCKS      = 8;
	localparam int MAX_NEST   = 255;

	// Fixed field widths of the request and result.
	localparam int MODE_W   = 2;
	localparam int REQ_W    = 4;
	localparam int LOCK_W   = 3;
	localparam int STATUS_W = 3;
	localparam int DEPTH_W  = 8;
	localparam int READERS_W = 5;

	// Derived storage widths.
	localparam int NEST_W    = $clog2(MAX_NEST + 1) + 1;
	localparam int MAG_W     = NEST_W - 1;
	localparam int RDR_W     = $clog2(REQUESTERS + 1);
	localparam int ENTRIES   = REQUESTERS * LOCKS;
	localparam int ADDR_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int LK_IDX_W  = (LOCKS > 1) ? $clog2(LOCKS) : 1;
	localparam int ADDR_EXT_W = ADDR_W + REQ_W + LOCK_W;
	localparam int DEPTH_MAX  = (1 << DEPTH_W) - 1;
	localparam int READERS_MAX = (1 << READERS_W) - 1;

	// Request modes.
	localparam logic [MODE_W-1:0] MODE_TRY_SHARED     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TRY_EXCLUSIVE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REL_SHARED     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_REL_EXCLUSIVE  = 2'd3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_DONE       = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_BUSY       = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_OTHER_MODE = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_NOT_HELD   = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_OVERFLOW   = 3'd4;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} rrwl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic execute;
	} rrwl_cmd_t;

endpackage

// ===== sv/rrwl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reader-writer lock unit controller
// Two-state sequencer: capture a request and read its table entry, then
// update the entry and the lock counters and issue the result.
// ----------------------------------------------------------------------------
module rrwl_ctrl
	import rrwl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output rrwl_cmd_t cmd
);

	rrwl_state_t state_q;
	rrwl_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_next = S_EXEC;
				end
			end
			S_EXEC: begin
				state_next = S_IDLE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy        = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = start;
			end
			S_EXEC: begin
				busy        = 1'b1;
				cmd.execute = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

// ===== sv/rrwl_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reader-writer lock unit datapath
// Nesting table memory with per-entry valid bits, per-lock reader counts and
// writer flags, the request decision logic and the result registers.
// ----------------------------------------------------------------------------
module rrwl_dp
	import rrwl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  rrwl_cmd_t            cmd,
	input  logic [MODE_W-1:0]    mode,
	input  logic [REQ_W-1:0]     requester,
	input  logic [LOCK_W-1:0]    lock_index,
	output logic                 done,
	output logic [STATUS_W-1:0]  status,
	output logic                 holds_shared,
	output logic                 holds_exclusive,
	output logic [DEPTH_W-1:0]   nesting_depth,
	output logic [READERS_W-1:0] readers_now
);

	// Nesting table: signed count per requester and lock.
	logic signed [NEST_W-1:0] nest_mem [ENTRIES];
	logic [ENTRIES-1:0]       nest_vld_q;

	logic [RDR_W-1:0] reader_q [LOCKS];
	logic [LOCKS-1:0] writer_q;

	// Request captured at acceptance.
	logic [MODE_W-1:0]        mode_q;
	logic [LK_IDX_W-1:0]      lk_q;
	logic [ADDR_W-1:0]        addr_q;
	logic                     in_range_q;
	logic signed [NEST_W-1:0] rd_q;
	logic                     rd_vld_q;

	// Result registers.
	logic                 done_q;
	logic [STATUS_W-1:0]  status_q;
	logic                 hold_sh_q;
	logic                 hold_ex_q;
	logic [DEPTH_W-1:0]   depth_q;
	logic [READERS_W-1:0] readers_q;

	logic [ADDR_EXT_W-1:0] addr_ext;
	logic [ADDR_W-1:0]     addr;
	logic                  in_range;

	logic signed [NEST_W-1:0] c_cur;
	logic signed [NEST_W-1:0] c_new;
	logic [MAG_W-1:0]         mag_cur;
	logic [MAG_W-1:0]         mag_new;
	logic [RDR_W-1:0]         rdr_cur;
	logic [RDR_W-1:0]         rdr_new;
	logic                     wr_cur;
	logic                     wr_new;
	logic [STATUS_W-1:0]      stat_new;

	assign addr_ext = ADDR_EXT_W'(requester) * ADDR_EXT_W'(LOCKS) + ADDR_EXT_W'(lock_index);
	assign addr     = addr_ext[ADDR_W-1:0];
	assign in_range = (32'(requester) < REQUESTERS) && (32'(lock_index) < LOCKS);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			lk_q   <= LK_IDX_W'(lock_index);
			addr_q <= addr;
			rd_q   <= nest_mem[addr];
		end
		if (cmd.execute && in_range_q) begin
			nest_mem[addr_q] <= c_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_range_q <= 1'b0;
			rd_vld_q   <= 1'b0;
		end else if (cmd.capture) begin
			in_range_q <= in_range;
			rd_vld_q   <= nest_vld_q[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nest_vld_q <= '0;
			writer_q   <= '0;
			for (int i = 0; i < LOCKS; i++) begin
				reader_q[i] <= '0;
			end
		end else if (cmd.execute && in_range_q) begin
			nest_vld_q[addr_q] <= 1'b1;
			writer_q[lk_q]     <= wr_new;
			reader_q[lk_q]     <= rdr_new;
		end
	end

	// An entry never written since reset reads as zero.
	assign c_cur   = rd_vld_q ? rd_q : '0;
	assign mag_cur = c_cur[NEST_W-1] ? MAG_W'(-c_cur) : MAG_W'(c_cur);
	assign mag_new = c_new[NEST_W-1] ? MAG_W'(-c_new) : MAG_W'(c_new);
	assign rdr_cur = reader_q[lk_q];
	assign wr_cur  = writer_q[lk_q];

	always_comb begin
		c_new    = c_cur;
		rdr_new  = rdr_cur;
		wr_new   = wr_cur;
		stat_new = STAT_DONE;
		unique case (mode_q)
			MODE_TRY_SHARED: begin
				if (c_cur == '0) begin
					if (wr_cur) begin
						stat_new = STAT_BUSY;
					end else begin
						rdr_new = rdr_cur + RDR_W'(1);
						c_new   = NEST_W'(1);
					end
				end else if (c_cur[NEST_W-1]) begin
					stat_new = STAT_OTHER_MODE;
				end else if (32'(mag_cur) >= MAX_NEST) begin
					stat_new = STAT_OVERFLOW;
				end else begin
					c_new = c_cur + NEST_W'(1);
				end
			end
			MODE_TRY_EXCLUSIVE: begin
				if (c_cur == '0) begin
					if (wr_cur || (rdr_cur != '0)) begin
						stat_new = STAT_BUSY;
					end else begin
						wr_new = 1'b1;
						c_new  = '1;
					end
				end else if (!c_cur[NEST_W-1]) begin
					stat_new = STAT_OTHER_MODE;
				end else if (32'(mag_cur) >= MAX_NEST) begin
					stat_new = STAT_OVERFLOW;
				end else begin
					c_new = c_cur - NEST_W'(1);
				end
			end
			MODE_REL_SHARED: begin
				if (c_cur == '0) begin
					stat_new = STAT_NOT_HELD;
				end else if (c_cur[NEST_W-1]) begin
					stat_new = STAT_OTHER_MODE;
				end else begin
					c_new = c_cur - NEST_W'(1);
					// The last nested release drops this requester from the readers.
					if ((c_cur == NEST_W'(1)) && (rdr_cur != '0)) begin
						rdr_new = rdr_cur - RDR_W'(1);
					end
				end
			end
			MODE_REL_EXCLUSIVE: begin
				if (c_cur == '0) begin
					stat_new = STAT_NOT_HELD;
				end else if (!c_cur[NEST_W-1]) begin
					stat_new = STAT_OTHER_MODE;
				end else begin
					c_new = c_cur + NEST_W'(1);
					if (c_cur == '1) begin
						wr_new = 1'b0;
					end
				end
			end
			default: begin
				stat_new = STAT_NOT_HELD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.execute;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			if (in_range_q) begin
				status_q  <= stat_new;
				hold_sh_q <= (c_new != '0) && !c_new[NEST_W-1];
				hold_ex_q <= c_new[NEST_W-1];
				depth_q   <= (32'(mag_new) > DEPTH_MAX) ? DEPTH_W'(DEPTH_MAX)
				                                       : DEPTH_W'(mag_new);
				readers_q <= (32'(rdr_new) > READERS_MAX) ? READERS_W'(READERS_MAX)
				                                          : READERS_W'(rdr_new);
			end else begin
				status_q  <= STAT_NOT_HELD;
				hold_sh_q <= 1'b0;
				hold_ex_q <= 1'b0;
				depth_q   <= '0;
				readers_q <= '0;
			end
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign holds_shared    = hold_sh_q;
	assign holds_exclusive = hold_ex_q;
	assign nesting_depth   = depth_q;
	assign readers_now     = readers_q;

endmodule

// ===== sv/reentrant_reader_writer_lock_unit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reentrant reader-writer lock unit
// Grants and releases shared and exclusive holds on a set of locks for a set
// of requesters, with per-requester nesting counts.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  request   start, busy          mode, requester, lock_index
//  result    done (one cycle)     status, holds_shared, holds_exclusive,
//                                 nesting_depth, readers_now
//
//  A request is taken when start is high and busy is low. Each item first
//  reads its nesting table entry, then does the read-modify-write of that
//  entry and the lock counters. done is registered and pulses in the cycle
//  after the update, and a new request can be taken in that cycle.
//  Reset clears all holds at once through per-entry valid bits, so there is
//  no clearing pass. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module reentrant_reader_writer_lock_unit_core
	import rrwl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [MODE_W-1:0]    mode,
	input  logic [REQ_W-1:0]     requester,
	input  logic [LOCK_W-1:0]    lock_index,
	output logic                 done,
	output logic [STATUS_W-1:0]  status,
	output logic                 holds_shared,
	output logic                 holds_exclusive,
	output logic [DEPTH_W-1:0]   nesting_depth,
	output logic [READERS_W-1:0] readers_now
);

	rrwl_cmd_t cmd;

	rrwl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	rrwl_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.mode            (mode),
		.requester       (requester),
		.lock_index      (lock_index),
		.done            (done),
		.status          (status),
		.holds_shared    (holds_shared),
		.holds_exclusive (holds_exclusive),
		.nesting_depth   (nesting_depth),
		.readers_now     (readers_now)
	);

endmodule

// ===== test/rrwl_lock_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reader-writer lock unit checker
// Watches the request and result channels and keeps its own copy of the
// nesting table and lock counters. Each result is compared field by field
// with the oldest outstanding outcome.
// ----------------------------------------------------------------------------
module rrwl_lock_checker
	import rrwl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic [MODE_W-1:0]    mode,
	input  logic [REQ_W-1:0]     requester,
	input  logic [LOCK_W-1:0]    lock_index,
	input  logic                 done,
	input  logic [STATUS_W-1:0]  status,
	input  logic                 holds_shared,
	input  logic                 holds_exclusive,
	input  logic [DEPTH_W-1:0]   nesting_depth,
	input  logic [READERS_W-1:0] readers_now,
	output int                   mismatches,
	output int                   outstanding
);

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic                 holds_shared;
		logic                 holds_exclusive;
		logic [DEPTH_W-1:0]   depth;
		logic [READERS_W-1:0] readers;
	} lock_outcome_t;

	// Signed nesting per requester and lock: positive shared, negative exclusive.
	int            nest_tab [REQUESTERS][LOCKS];
	int            shared_holders [LOCKS];
	bit            excl_held [LOCKS];
	lock_outcome_t outcome_q [$];
	int            err_n;

	function automatic lock_outcome_t apply_request(input logic [MODE_W-1:0] m,
			input logic [REQ_W-1:0] r, input logic [LOCK_W-1:0] l);
		lock_outcome_t o;
		int            c;
		int            mag;
		o = '0;
		if (int'(r) >= REQUESTERS || int'(l) >= LOCKS) begin
			o.status = STAT_NOT_HELD;
			return o;
		end
		c = nest_tab[r][l];
		o.status = STAT_DONE;
		case (m)
			MODE_TRY_SHARED: begin
				if (c == 0) begin
					if (excl_held[l]) begin
						o.status = STAT_BUSY;
					end else begin
						shared_holders[l]++;
						c = 1;
					end
				end else if (c < 0) begin
					o.status = STAT_OTHER_MODE;
				end else if (c >= MAX_NEST) begin
					o.status = STAT_OVERFLOW;
				end else begin
					c++;
				end
			end
			MODE_TRY_EXCLUSIVE: begin
				if (c == 0) begin
					if (excl_held[l] || shared_holders[l] != 0) begin
						o.status = STAT_BUSY;
					end else begin
						excl_held[l] = 1'b1;
						c = -1;
					end
				end else if (c > 0) begin
					o.status = STAT_OTHER_MODE;
				end else if (-c >= MAX_NEST) begin
					o.status = STAT_OVERFLOW;
				end else begin
					c--;
				end
			end
			MODE_REL_SHARED: begin
				if (c == 0) begin
					o.status = STAT_NOT_HELD;
				end else if (c < 0) begin
					o.status = STAT_OTHER_MODE;
				end else begin
					c--;
					if (c == 0 && shared_holders[l] != 0)
						shared_holders[l]--;
				end
			end
			default: begin
				if (c == 0) begin
					o.status = STAT_NOT_HELD;
				end else if (c > 0) begin
					o.status = STAT_OTHER_MODE;
				end else begin
					c++;
					if (c == 0)
						excl_held[l] = 1'b0;
				end
			end
		endcase
		nest_tab[r][l] = c;
		mag = (c < 0) ? -c : c;
		o.holds_shared    = (c > 0);
		o.holds_exclusive = (c < 0);
		o.depth   = (mag > DEPTH_MAX) ? DEPTH_W'(DEPTH_MAX) : DEPTH_W'(mag);
		o.readers = (shared_holders[l] > READERS_MAX) ? READERS_W'(READERS_MAX)
			: READERS_W'(shared_holders[l]);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lock_outcome_t want;
		if (!arst_n) begin
			foreach (nest_tab[r, l])
				nest_tab[r][l] = 0;
			foreach (shared_holders[l]) begin
				shared_holders[l] = 0;
				excl_held[l] = 1'b0;
			end
			outcome_q.delete();
			err_n = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			// The result is retired before a new request is taken, since a
			// result can never belong to the request accepted at the same edge.
			if (done) begin
				if (outcome_q.size() == 0) begin
					$error("result with no request outstanding");
					err_n++;
				end else begin
					want = outcome_q.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						err_n++;
					end
					if (holds_shared !== want.holds_shared) begin
						$error("holds_shared: expected %0d, actual %0d",
							want.holds_shared, holds_shared);
						err_n++;
					end
					if (holds_exclusive !== want.holds_exclusive) begin
						$error("holds_exclusive: expected %0d, actual %0d",
							want.holds_exclusive, holds_exclusive);
						err_n++;
					end
					if (nesting_depth !== want.depth) begin
						$error("nesting_depth: expected %0d, actual %0d",
							want.depth, nesting_depth);
						err_n++;
					end
					if (readers_now !== want.readers) begin
						$error("readers_now: expected %0d, actual %0d",
							want.readers, readers_now);
						err_n++;
					end
				end
			end
			if (start && !busy)
				outcome_q.push_back(apply_request(mode, requester, lock_index));
			mismatches  <= err_n;
			outstanding <= outcome_q.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reader-writer lock unit testbench
// Drives directed and random lock requests into the unit with random idle
// bursts, lets the checker predict and compare every result, and reports
// the verdict once all results are in.
// ----------------------------------------------------------------------------
module tb_top
	import rrwl_pkg::*;
();

	localparam int RANDOM_ITEMS = 160;
	localparam int TAIL_ITEMS   = 40;
	localparam int STALL_LIMIT  = 2000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [MODE_W-1:0]    mode = MODE_TRY_SHARED;
	logic [REQ_W-1:0]     requester = '0;
	logic [LOCK_W-1:0]    lock_index = '0;
	logic                 done;
	logic [STATUS_W-1:0]  status;
	logic                 holds_shared;
	logic                 holds_exclusive;
	logic [DEPTH_W-1:0]   nesting_depth;
	logic [READERS_W-1:0] readers_now;
	int                   mismatches;
	int                   outstanding;

	int sent = 0;
	int stall_cycles = 0;
	bit idle_ok = 1'b1;
	bit quiet = 1'b0;

	always #1 clk = ~clk;

	reentrant_reader_writer_lock_unit_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .requester(requester), .lock_index(lock_index),
		.done(done), .status(status), .holds_shared(holds_shared),
		.holds_exclusive(holds_exclusive), .nesting_depth(nesting_depth),
		.readers_now(readers_now)
	);

	rrwl_lock_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .requester(requester), .lock_index(lock_index),
		.done(done), .status(status), .holds_shared(holds_shared),
		.holds_exclusive(holds_exclusive), .nesting_depth(nesting_depth),
		.readers_now(readers_now), .mismatches(mismatches),
		.outstanding(outstanding)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Holds the request until it is taken, then maybe drops start for a burst.
	task automatic send_request(input logic [MODE_W-1:0] m, input logic [REQ_W-1:0] r,
			input logic [LOCK_W-1:0] l);
		start      <= 1'b1;
		mode       <= m;
		requester  <= r;
		lock_index <= l;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
		if (sent % 64 == 0)
			quiet = ($urandom_range(0, 2) == 0);
		if (idle_ok && !quiet && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 17))
				@(posedge clk);
		end
	endtask

	// Climbs one entry to the nesting limit with two requests past it, then back down with one release past zero.
	task automatic climb_nesting(input logic exclusive, input logic [REQ_W-1:0] r,
			input logic [LOCK_W-1:0] l);
		repeat (MAX_NEST + 2)
			send_request(exclusive ? MODE_TRY_EXCLUSIVE : MODE_TRY_SHARED, r, l);
		repeat (MAX_NEST + 1)
			send_request(exclusive ? MODE_REL_EXCLUSIVE : MODE_REL_SHARED, r, l);
	endtask

	task automatic nested_burst();
		logic [REQ_W-1:0]  r;
		logic [LOCK_W-1:0] l;
		logic              exclusive;
		int                n;
		r = REQ_W'($urandom_range(0, 3));
		l = LOCK_W'($urandom_range(0, 1));
		exclusive = 1'($urandom_range(0, 1));
		n = $urandom_range(1, 6);
		repeat (n)
			send_request(exclusive ? MODE_TRY_EXCLUSIVE : MODE_TRY_SHARED, r, l);
		repeat (n)
			send_request(exclusive ? MODE_REL_EXCLUSIVE : MODE_REL_SHARED, r, l);
	endtask

	// Every requester takes the same lock shared, in shuffled order, then one tries it exclusive and all release it.
	task automatic fill_readers();
		int                order [REQUESTERS];
		int                j;
		int                t;
		logic [LOCK_W-1:0] l;
		l = LOCK_W'($urandom_range(0, LOCKS - 1));
		foreach (order[i])
			order[i] = i;
		for (int i = REQUESTERS - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		foreach (order[i])
			send_request(MODE_TRY_SHARED, REQ_W'(order[i]), l);
		send_request(MODE_TRY_EXCLUSIVE, REQ_W'($urandom_range(0, REQUESTERS - 1)), l);
		foreach (order[i])
			send_request(MODE_REL_SHARED, REQ_W'(order[i]), l);
	endtask

	task automatic hot_request();
		logic [REQ_W-1:0]  r;
		logic [LOCK_W-1:0] l;
		if ($urandom_range(0, 4) == 0) begin
			r = REQ_W'($urandom_range(0, REQUESTERS - 1));
			l = LOCK_W'($urandom_range(0, LOCKS - 1));
		end else begin
			r = REQ_W'($urandom_range(0, 3));
			l = LOCK_W'($urandom_range(0, 1));
		end
		send_request(MODE_W'($urandom_range(0, 3)), r, l);
	endtask

	initial begin
		int base;
		int pick;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Releases with nothing held, then nesting and mode conflicts on two locks.
		send_request(MODE_REL_SHARED, 4'd0, 3'd0);
		send_request(MODE_REL_EXCLUSIVE, 4'd0, 3'd0);
		send_request(MODE_TRY_SHARED, 4'd0, 3'd0);
		send_request(MODE_TRY_SHARED, 4'd0, 3'd0);
		send_request(MODE_TRY_EXCLUSIVE, 4'd0, 3'd0);
		send_request(MODE_REL_EXCLUSIVE, 4'd0, 3'd0);
		send_request(MODE_TRY_EXCLUSIVE, 4'd1, 3'd0);
		send_request(MODE_TRY_SHARED, 4'd1, 3'd0);
		send_request(MODE_REL_SHARED, 4'd0, 3'd0);
		send_request(MODE_REL_SHARED, 4'd0, 3'd0);
		send_request(MODE_REL_SHARED, 4'd1, 3'd0);
		send_request(MODE_TRY_EXCLUSIVE, 4'd15, 3'd7);
		send_request(MODE_TRY_SHARED, 4'd14, 3'd7);
		send_request(MODE_TRY_EXCLUSIVE, 4'd14, 3'd7);
		send_request(MODE_TRY_SHARED, 4'd15, 3'd7);
		send_request(MODE_REL_SHARED, 4'd15, 3'd7);
		send_request(MODE_TRY_EXCLUSIVE, 4'd15, 3'd7);
		send_request(MODE_REL_EXCLUSIVE, 4'd15, 3'd7);
		send_request(MODE_REL_EXCLUSIVE, 4'd15, 3'd7);
		send_request(MODE_REL_EXCLUSIVE, 4'd15, 3'd7);

		climb_nesting(1'b0, 4'd15, 3'd7);
		climb_nesting(1'b1, 4'd0, 3'd3);

		base = sent;
		while (sent - base < RANDOM_ITEMS) begin
			idle_ok = (sent - base) < RANDOM_ITEMS - TAIL_ITEMS;
			pick = $urandom_range(0, 99);
			if (pick < 65)
				hot_request();
			else if (pick < 82)
				nested_burst();
			else if (pick < 88)
				fill_readers();
			else
				send_request(MODE_W'($urandom_range(0, 3)),
					REQ_W'($urandom_range(0, REQUESTERS - 1)),
					LOCK_W'($urandom_range(0, LOCKS - 1)));
		end

		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/rrwl_pkg.sv
sv/rrwl_ctrl.sv
sv/rrwl_dp.sv
sv/reentrant_reader_writer_lock_unit_core.sv
test/rrwl_lock_checker.sv
test/tb_top.sv
